// ===== design/sfh_pkg.sv =====
// Shared constants and mixing functions for the seeded hash block.
package sfh_pkg;

   localparam int unsigned WORD_BITS  = 32;
   localparam int unsigned COUNT_BITS = 3;

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   // Byte counts of a word
   localparam count_type COUNT_EMPTY = 3'd0;
   localparam count_type COUNT_ONE   = 3'd1;
   localparam count_type COUNT_TWO   = 3'd2;
   localparam count_type COUNT_THREE = 3'd3;
   localparam count_type COUNT_FULL  = 3'd4;

   // One main-loop round over a full 4-byte word
   function automatic word_type full_round(input word_type h_in, input word_type w);
      word_type h;
      word_type t;
      h = h_in + {16'h0000, w[15:0]};
      t = ({16'h0000, w[31:16]} << 11) ^ h;
      h = (h << 16) ^ t;
      h = h + (h >> 11);
      return h;
   endfunction

   // Tail mix for a last word of one to three bytes; others pass through
   function automatic word_type tail_mix(input word_type h_in, input word_type w,
                                         input count_type n);
      word_type h;
      h = h_in;
      case (n)
         COUNT_THREE: begin
            h = h + {16'h0000, w[15:0]};
            h = h ^ (h << 16);
            h = h ^ ({24'h000000, w[23:16]} << 18);
            h = h + (h >> 11);
         end
         COUNT_TWO: begin
            h = h + {16'h0000, w[15:0]};
            h = h ^ (h << 11);
            h = h + (h >> 17);
         end
         COUNT_ONE: begin
            h = h + {24'h000000, w[7:0]};
            h = h ^ (h << 10);
            h = h + (h >> 1);
         end
         default: h = h_in;
      endcase
      return h;
   endfunction

   // Final avalanche over the finished hash
   function automatic word_type avalanche(input word_type h_in);
      word_type h;
      h = h_in;
      h = h ^ (h << 3);
      h = h + (h >> 5);
      h = h ^ (h << 4);
      h = h + (h >> 17);
      h = h ^ (h << 25);
      h = h + (h >> 6);
      return h;
   endfunction

endpackage

// ===== design/seeded_superfast_hash.sv =====
// Seeded 32-bit hash over a message streamed as little-endian words.
// Registers: a word is registered in the input register on accept, and a last word's hash is
//   then registered in the result register, which drives rsp_valid and rsp_hash_value.
// Throughput: one word per cycle; the running hash loop closes through one round, tail mix
//   and avalanche; a last word waits in the input register only while a result is stalled.
// Reset: synchronous; clears both valid flags and the running hash to zero.
module seeded_superfast_hash (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_first_word,
   input  sfh_pkg::word_type  req_seed,
   input  sfh_pkg::word_type  req_data_word,
   input  sfh_pkg::count_type req_byte_count,
   input  logic               req_last_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sfh_pkg::word_type  rsp_hash_value
);
   import sfh_pkg::*;

   // Input register
   logic      s1_valid_ff, s1_valid_in;
   logic      s1_first_ff;
   word_type  s1_seed_ff;
   word_type  s1_data_ff;
   count_type s1_count_ff;
   logic      s1_last_ff;

   // Running hash and result register
   word_type  running_hash_ff, running_hash_in;
   logic      rsp_valid_ff, rsp_valid_in;
   word_type  hash_value_ff, hash_value_in;

   logic      rsp_free;
   logic      s1_move;
   logic      req_take;
   word_type  start_hash;
   count_type count_sat;
   word_type  mixed_hash;
   word_type  final_hash;

   // Output slot frees when empty or taken this cycle
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   // A non-last word never needs the output slot
   assign s1_move   = s1_valid_ff && (!s1_last_ff || rsp_free);
   assign req_stall = s1_valid_ff && !s1_move;
   assign req_take  = req_valid && !req_stall;

   // Hash one word against the running state
   always_comb begin
      start_hash = s1_first_ff ? s1_seed_ff : running_hash_ff;
      count_sat  = (s1_count_ff > COUNT_FULL) ? COUNT_FULL : s1_count_ff;
      if (!s1_last_ff || count_sat == COUNT_FULL) begin
         mixed_hash = full_round(start_hash, s1_data_ff);
      end else begin
         mixed_hash = tail_mix(start_hash, s1_data_ff, count_sat);
      end
      if (s1_first_ff && count_sat == COUNT_EMPTY) begin
         final_hash = '0;
      end else begin
         final_hash = avalanche(mixed_hash);
      end
   end

   // Next-state selection
   always_comb begin
      s1_valid_in     = req_take || (s1_valid_ff && !s1_move);
      running_hash_in = running_hash_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      hash_value_in   = hash_value_ff;
      if (s1_move) begin
         running_hash_in = s1_last_ff ? final_hash : mixed_hash;
         if (s1_last_ff) begin
            rsp_valid_in  = 1'b1;
            hash_value_in = final_hash;
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         running_hash_ff <= '0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         running_hash_ff <= running_hash_in;
      end
   end

   // Capture payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_first_ff <= req_first_word;
         s1_seed_ff  <= req_seed;
         s1_data_ff  <= req_data_word;
         s1_count_ff <= req_byte_count;
         s1_last_ff  <= req_last_word;
      end
      hash_value_ff <= hash_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = hash_value_ff;

   // A finished last word leaves its result in both the output and the running state
   a_last_result: assert property (@(posedge clock) disable iff (reset)
      s1_move && s1_last_ff |=> rsp_valid_ff && hash_value_ff == running_hash_ff)
      else $error("last word result does not match running hash");

   // Input stalls only behind a blocked result
   a_stall_cause: assert property (@(posedge clock)
      req_stall |-> s1_valid_ff && s1_last_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

   // A non-last word leaves a waiting result untouched
   a_nonlast_keeps: assert property (@(posedge clock) disable iff (reset)
      s1_move && !s1_last_ff && rsp_valid_ff && rsp_stall
      |=> rsp_valid_ff && $stable(hash_value_ff))
      else $error("non-last word disturbed waiting result");

   // Nothing is presented right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff)
      else $error("valid set after reset");

endmodule
